[hw/rtl/sync_framed_crc8_frame_router_top_macros.svh]
// ----------------------------------------------------------------------------
// frame router assertion macros
// shared concurrent assertion forms for the frame router rtl
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_CRC8_FRAME_ROUTER_TOP_MACROS_SVH
`define SYNC_FRAMED_CRC8_FRAME_ROUTER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SFCR8_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame router check failed");

// next-cycle implication, checked out of reset
`define SFCR8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame router check failed");

`endif

[hw/rtl/sfcr8_pkg.sv]
// ----------------------------------------------------------------------------
// frame router package
// constants, verdict codes and the crc-8 byte step for the frame router
// ----------------------------------------------------------------------------
`default_nettype none

package sfcr8_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int PEER_SLOTS_DEF  = 8;

	localparam logic [7:0] SYNC_FIRST   = 8'hA5;
	localparam logic [7:0] SYNC_SECOND  = 8'h5A;
	localparam logic [7:0] CRC_POLY     = 8'h07;
	localparam logic [7:0] BROADCAST_ID = 8'hFF;

	// header byte positions
	localparam int POS_VERSION = 2;
	localparam int POS_SENDER  = 4;
	localparam int POS_LENGTH  = 6;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEER_COUNT       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEER_IDS         = 2'd2;

	typedef enum logic [2:0] {
		V_NONE    = 3'd0,
		V_ROUTED  = 3'd1,
		V_BADCRC  = 3'd2,
		V_BADVER  = 3'd3,
		V_TOOLONG = 3'd4,
		V_NOPEER  = 3'd5
	} verdict_t;

	// crc-8, msb first, no reflection, no final xor
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] v;
		v = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/sync_framed_crc8_frame_router_top.sv]
// ----------------------------------------------------------------------------
// sync-framed crc-8 frame router
// byte-wise deframer with crc-8 check, version check and sender routing
// ----------------------------------------------------------------------------
// One received byte per transfer in, exactly one result per byte out. The
// block hunts for the sync pair 0xA5 0x5A, reads a five-byte header (version,
// type, sender, sequence, length), the payload and a closing crc-8 byte
// (poly 0x07, init 0, over header and payload). The crc byte carries the
// verdict: crc first, then version, then routing by sender (0xFF reaches every
// configured peer, else the first matching id as a one-hot mask). A length
// above MAX_PAYLOAD ends the attempt on the length byte itself. Throughput is
// one byte per clock while the result side does not stall; an input register
// is followed by a result register, with the frame state, crc byte step and
// eight-way id compare all done in the one logic stage between them. The input
// side keeps taking bytes while a finished result waits, until both stages are full.
// Configuration is taken on any cycle (cfg_ready is always high) and must only
// be written while the block is idle; index 3 is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_framed_crc8_frame_router_top_macros.svh"

module sync_framed_crc8_frame_router_top
	import sfcr8_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int PEER_SLOTS  = PEER_SLOTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	// byte input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           rx_byte,

	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      in_frame,
	output logic [5:0]                byte_pos,
	output logic [7:0]                byte_echo,
	output logic                      frame_end,
	output logic [2:0]                verdict,
	output logic [7:0]                dest_mask,
	output logic [5:0]                frame_len,
	output logic [7:0]                sender,

	// configuration write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data
);

	// position runs up to 7 + MAX_PAYLOAD on the crc byte
	localparam int POS_W = $clog2(MAX_PAYLOAD + 9);
	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int PID_W = PEER_SLOTS * 8;

	typedef enum logic [2:0] {
		PH_HUNT0,
		PH_HUNT1,
		PH_HEADER,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	// configuration registers
	logic [7:0]       expected_version_q;
	logic [3:0]       peer_count_q;
	logic [PID_W-1:0] peer_ids_q;

	// frame state
	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] position_q, position_d;
	logic [LEN_W-1:0] length_q, length_d;
	logic [7:0]       crc_q, crc_d;
	logic [7:0]       version_q, version_d;
	logic [7:0]       sender_q, sender_d;

	// input register
	logic             valid_s1;
	logic [7:0]       byte_s1;

	// result register
	logic             out_valid_q;
	logic             in_frame_q;
	logic [5:0]       byte_pos_q;
	logic [7:0]       byte_echo_q;
	logic             frame_end_q;
	verdict_t         verdict_q;
	logic [7:0]       dest_mask_q;
	logic [5:0]       frame_len_q;
	logic [7:0]       sender_out_q;

	// combinational result of the byte in the input register
	logic             inf_c;
	logic [5:0]       pos_c;
	logic             end_c;
	verdict_t         verd_c;
	logic [7:0]       mask_c;
	logic [5:0]       len_c;
	logic [7:0]       snd_c;
	logic [7:0]       route_c;
	logic [POS_W-1:0] pos_next;
	logic [POS_W-1:0] total_len;
	logic             advance;

	// the byte moves on when the result register is free or being emptied
	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign cfg_ready = 1'b1;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_version_q <= 8'd1;
			peer_count_q       <= 4'd1;
			peer_ids_q         <= PID_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EXPECTED_VERSION: expected_version_q <= cfg_data[7:0];
				REG_PEER_COUNT:       peer_count_q       <= cfg_data[3:0];
				REG_PEER_IDS:         peer_ids_q         <= cfg_data[PID_W-1:0];
				default:              ;
			endcase
		end
	end

	// ---------------- routing ----------------
	// broadcast marks every live entry, otherwise the first live match wins;
	// a count above the slot number simply makes all slots live
	always_comb begin
		logic found;
		logic live;
		found   = 1'b0;
		route_c = '0;
		for (int i = 0; i < PEER_SLOTS; i++) begin
			live = 4'(i) < peer_count_q;
			if (sender_q == BROADCAST_ID) begin
				route_c[i] = live;
			end else if (live && !found && peer_ids_q[i*8 +: 8] == sender_q) begin
				route_c[i] = 1'b1;
				found      = 1'b1;
			end
		end
	end

	assign pos_next  = position_q + POS_W'(1);
	assign total_len = POS_W'(length_q) + POS_W'(8);

	// ---------------- frame state step ----------------
	always_comb begin
		phase_d    = phase_q;
		position_d = position_q;
		length_d   = length_q;
		crc_d      = crc_q;
		version_d  = version_q;
		sender_d   = sender_q;
		inf_c      = 1'b0;
		pos_c      = '0;
		end_c      = 1'b0;
		verd_c     = V_NONE;
		mask_c     = '0;
		len_c      = '0;
		snd_c      = '0;

		unique case (phase_q)
			PH_HUNT0: begin
				if (byte_s1 == SYNC_FIRST) begin
					inf_c   = 1'b1;
					phase_d = PH_HUNT1;
				end
			end
			PH_HUNT1: begin
				// a wrong second sync byte is dropped, not retried as a first
				if (byte_s1 == SYNC_SECOND) begin
					inf_c      = 1'b1;
					pos_c      = 6'd1;
					position_d = POS_W'(2);
					crc_d      = '0;
					phase_d    = PH_HEADER;
				end else begin
					phase_d = PH_HUNT0;
				end
			end
			PH_HEADER: begin
				inf_c      = 1'b1;
				pos_c      = 6'(position_q);
				crc_d      = crc8_step(crc_q, byte_s1);
				position_d = pos_next;
				if (position_q == POS_W'(POS_VERSION)) begin
					version_d = byte_s1;
				end
				if (position_q == POS_W'(POS_SENDER)) begin
					sender_d = byte_s1;
				end
				if (position_q >= POS_W'(POS_LENGTH)) begin
					length_d = LEN_W'(byte_s1);
					if (byte_s1 > 8'(MAX_PAYLOAD)) begin
						end_c   = 1'b1;
						verd_c  = V_TOOLONG;
						snd_c   = sender_q;
						phase_d = PH_HUNT0;
					end else if (byte_s1 == 8'd0) begin
						phase_d = PH_CHECK;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				inf_c      = 1'b1;
				pos_c      = 6'(position_q);
				crc_d      = crc8_step(crc_q, byte_s1);
				position_d = pos_next;
				if (pos_next >= POS_W'(length_q) + POS_W'(7)) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				inf_c   = 1'b1;
				pos_c   = 6'(position_q);
				end_c   = 1'b1;
				snd_c   = sender_q;
				len_c   = 6'(total_len);
				phase_d = PH_HUNT0;
				if (byte_s1 != crc_q) begin
					verd_c = V_BADCRC;
				end else if (version_q != expected_version_q) begin
					verd_c = V_BADVER;
				end else if (route_c != 8'd0) begin
					verd_c = V_ROUTED;
					mask_c = route_c;
				end else begin
					verd_c = V_NOPEER;
				end
			end
			default: phase_d = PH_HUNT0;
		endcase
	end

	// ---------------- input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// ---------------- frame state and result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT0;
			position_q   <= '0;
			length_q     <= '0;
			crc_q        <= '0;
			version_q    <= '0;
			sender_q     <= '0;
			out_valid_q  <= 1'b0;
			in_frame_q   <= 1'b0;
			byte_pos_q   <= '0;
			byte_echo_q  <= '0;
			frame_end_q  <= 1'b0;
			verdict_q    <= V_NONE;
			dest_mask_q  <= '0;
			frame_len_q  <= '0;
			sender_out_q <= '0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				phase_q      <= phase_d;
				position_q   <= position_d;
				length_q     <= length_d;
				crc_q        <= crc_d;
				version_q    <= version_d;
				sender_q     <= sender_d;
				in_frame_q   <= inf_c;
				byte_pos_q   <= pos_c;
				byte_echo_q  <= byte_s1;
				frame_end_q  <= end_c;
				verdict_q    <= verd_c;
				dest_mask_q  <= mask_c;
				frame_len_q  <= len_c;
				sender_out_q <= snd_c;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign in_frame  = in_frame_q;
	assign byte_pos  = byte_pos_q;
	assign byte_echo = byte_echo_q;
	assign frame_end = frame_end_q;
	assign verdict   = verdict_q;
	assign dest_mask = dest_mask_q;
	assign frame_len = frame_len_q;
	assign sender    = sender_out_q;

	// ---------------- assertions ----------------
	// a mask is present exactly for a routed verdict
	`SFCR8_ASSERT_NOW(a_mask_iff_routed, clk, arst_n, out_valid_q,
		(verdict_q == V_ROUTED) == (dest_mask_q != 8'd0))
	// a unicast route hits one peer only
	`SFCR8_ASSERT_NOW(a_unicast_onehot, clk, arst_n,
		out_valid_q && verdict_q == V_ROUTED && sender_out_q != BROADCAST_ID,
		$onehot(dest_mask_q))
	// bytes outside a frame carry no position and never end one
	`SFCR8_ASSERT_NOW(a_outside_frame, clk, arst_n, out_valid_q && !in_frame_q,
		byte_pos_q == 6'd0 && !frame_end_q)
	// the end of any attempt sends the deframer back to hunting
	`SFCR8_ASSERT_NEXT(a_end_rehunt, clk, arst_n, advance && end_c,
		phase_q == PH_HUNT0)

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// frame router testbench
// streams bytes through the deframer and checks every result against a model
// ----------------------------------------------------------------------------
// Each byte taken on the input channel is run through a behavioural model of
// the deframer. The model keeps its own copy of the frame state and of the
// registers, and queues one expected result per byte. Results taken on the
// output channel are compared field by field, oldest first. The traffic is
// mostly well-formed frames with random content: some carry a bad crc, a
// wrong version, an unknown sender, a broadcast sender or an oversize length.
// Between them come noise bytes and broken sync pairs. The registers are
// rewritten between phases, once the block has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
	import sfcr8_pkg::*;
();

	localparam int CYCLE_LIMIT = 400000;
	localparam int CALM_FROM   = 450;
	localparam int CALM_TO     = 700;
	localparam int DRAIN_TAIL  = 8;

	// index 3 is decoded by nobody
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		ST_HUNT_A5,
		ST_HUNT_5A,
		ST_HEADER,
		ST_PAYLOAD,
		ST_CRC
	} deframe_st_t;

	typedef struct {
		logic       in_frame;
		logic [5:0] pos;
		logic [7:0] echo;
		logic       fend;
		verdict_t   verd;
		logic [7:0] mask;
		logic [5:0] len;
		logic [7:0] snd;
	} byte_result_t;

	// model of the deframer plus the queue of results still owed by the block
	class frame_scoreboard;
		logic [7:0]   exp_version;
		logic [3:0]   n_peers;
		logic [63:0]  id_table;
		deframe_st_t  st;
		logic [7:0]   pos_cnt;
		logic [7:0]   pay_len;
		logic [7:0]   crc;
		logic [7:0]   ver_seen;
		logic [7:0]   snd_seen;
		byte_result_t owed_q[$];
		int           mismatches;
		int           checked;
		int           verdict_hits[8];

		function new();
			exp_version = 8'd1;
			n_peers     = 4'd1;
			id_table    = 64'd1;
			st          = ST_HUNT_A5;
			pos_cnt     = 8'd0;
			pay_len     = 8'd0;
			crc         = 8'd0;
			ver_seen    = 8'd0;
			snd_seen    = 8'd0;
			mismatches  = 0;
			checked     = 0;
			foreach (verdict_hits[i]) verdict_hits[i] = 0;
		endfunction

		// bit-serial form of the msb-first crc-8 byte update
		static function logic [7:0] crc_byte(logic [7:0] c, logic [7:0] d);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[7] ^ d[i];
				c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
			end
			return c;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
			case (idx)
				REG_EXPECTED_VERSION: exp_version = val[7:0];
				REG_PEER_COUNT:       n_peers = val[3:0];
				REG_PEER_IDS:         id_table = val;
				default: ;
			endcase
		endfunction

		function logic [7:0] dest_for(logic [7:0] id);
			int         live;
			logic [7:0] m;
			live = (n_peers > PEER_SLOTS_DEF) ? PEER_SLOTS_DEF : n_peers;
			m = 8'h00;
			if (id == BROADCAST_ID) begin
				for (int i = 0; i < live; i++) m[i] = 1'b1;
				return m;
			end
			for (int i = 0; i < live; i++)
				if (id_table[8*i +: 8] == id) return 8'(1 << i);
			return m;
		endfunction

		function void note_input(logic [7:0] b);
			byte_result_t r;
			r.in_frame = 1'b0;
			r.pos      = 6'd0;
			r.echo     = b;
			r.fend     = 1'b0;
			r.verd     = V_NONE;
			r.mask     = 8'h00;
			r.len      = 6'd0;
			r.snd      = 8'h00;
			case (st)
				ST_HUNT_A5: begin
					if (b == SYNC_FIRST) begin
						r.in_frame = 1'b1;
						st = ST_HUNT_5A;
					end
				end
				ST_HUNT_5A: begin
					if (b == SYNC_SECOND) begin
						r.in_frame = 1'b1;
						r.pos = 6'd1;
						pos_cnt = 8'd2;
						crc = 8'h00;
						st = ST_HEADER;
					end else begin
						st = ST_HUNT_A5;
					end
				end
				ST_HEADER: begin
					r.in_frame = 1'b1;
					r.pos = pos_cnt[5:0];
					crc = crc_byte(crc, b);
					if (pos_cnt == POS_VERSION) ver_seen = b;
					if (pos_cnt == POS_SENDER) snd_seen = b;
					if (pos_cnt >= POS_LENGTH) begin
						pay_len = b;
						if (b > MAX_PAYLOAD_DEF) begin
							r.fend = 1'b1;
							r.verd = V_TOOLONG;
							r.snd = snd_seen;
							st = ST_HUNT_A5;
						end else begin
							st = (b == 8'd0) ? ST_CRC : ST_PAYLOAD;
						end
					end
					pos_cnt++;
				end
				ST_PAYLOAD: begin
					r.in_frame = 1'b1;
					r.pos = pos_cnt[5:0];
					crc = crc_byte(crc, b);
					pos_cnt++;
					if (pos_cnt >= 7 + pay_len) st = ST_CRC;
				end
				default: begin
					r.in_frame = 1'b1;
					r.pos = pos_cnt[5:0];
					r.fend = 1'b1;
					r.snd = snd_seen;
					r.len = 6'(8 + pay_len);
					if (b != crc) begin
						r.verd = V_BADCRC;
					end else if (ver_seen != exp_version) begin
						r.verd = V_BADVER;
					end else begin
						r.mask = dest_for(snd_seen);
						r.verd = (r.mask != 8'h00) ? V_ROUTED : V_NOPEER;
					end
					st = ST_HUNT_A5;
				end
			endcase
			owed_q.push_back(r);
		endfunction

		function string describe(byte_result_t r);
			return $sformatf({"frame=%0b pos=%0d echo=%02h end=%0b verdict=%0d",
				" mask=%02h len=%0d sender=%02h"}, r.in_frame, r.pos, r.echo,
				r.fend, r.verd, r.mask, r.len, r.snd);
		endfunction

		function void check(byte_result_t act);
			byte_result_t e;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result, nothing owed: %s", describe(act));
				return;
			end
			e = owed_q.pop_front();
			checked++;
			verdict_hits[e.verd]++;
			if (act.in_frame !== e.in_frame || act.pos !== e.pos || act.echo !== e.echo ||
					act.fend !== e.fend || act.verd !== e.verd || act.mask !== e.mask ||
					act.len !== e.len || act.snd !== e.snd) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on result %0d\n  expected %s\n  actual   %s",
						checked, describe(e), describe(act));
			end
		endfunction
	endclass

	// clock, reset and block inputs, all known from time zero
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic [7:0]           rx_byte = 8'h00;
	logic                 out_stall = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data = 64'd0;

	logic       in_stall;
	logic       out_valid;
	logic       in_frame;
	logic [5:0] byte_pos;
	logic [7:0] byte_echo;
	logic       frame_end;
	logic [2:0] verdict;
	logic [7:0] dest_mask;
	logic [5:0] frame_len;
	logic [7:0] sender;
	logic       cfg_ready;

	frame_scoreboard sb = new();
	int  bytes_sent = 0;
	int  cycle_count = 0;
	wire calm = (bytes_sent >= CALM_FROM) && (bytes_sent < CALM_TO);

	sync_framed_crc8_frame_router_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.in_frame  (in_frame),
		.byte_pos  (byte_pos),
		.byte_echo (byte_echo),
		.frame_end (frame_end),
		.verdict   (verdict),
		.dest_mask (dest_mask),
		.frame_len (frame_len),
		.sender    (sender),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side: take what the block offers, then pick the next stall
	// (stall only moves at the edge, so a waiting result sees a steady stall)
	always @(posedge clk) begin
		byte_result_t act;
		if (out_valid && !out_stall) begin
			act.in_frame = in_frame;
			act.pos      = byte_pos;
			act.echo     = byte_echo;
			act.fend     = frame_end;
			act.verd     = verdict_t'(verdict);
			act.mask     = dest_mask;
			act.len      = frame_len;
			act.snd      = sender;
			sb.check(act);
		end
		out_stall <= !calm && ($urandom_range(99) < 32);
	end

	// watchdog on the whole run
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("run timed out after %0d cycles", cycle_count);
		$display("[FAIL] regression broken");
		$finish;
	end

	// one byte transfer, with random idle cycles in front of it
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.note_input(b);
		bytes_sent++;
	endtask

	// sync pair, header, payload and crc; an oversize length stops the frame
	// right after the length byte, as the block gives up there
	task automatic send_frame(input logic [7:0] ver, input logic [7:0] who,
			input logic [7:0] plen, input bit crc_ok);
		logic [7:0] hdr [5];
		logic [7:0] c;
		logic [7:0] d;
		hdr[0] = ver;
		hdr[1] = 8'($urandom);
		hdr[2] = who;
		hdr[3] = 8'($urandom);
		hdr[4] = plen;
		c = 8'h00;
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		foreach (hdr[i]) begin
			c = frame_scoreboard::crc_byte(c, hdr[i]);
			send_byte(hdr[i]);
		end
		if (plen <= MAX_PAYLOAD_DEF) begin
			for (int i = 0; i < plen; i++) begin
				d = 8'($urandom);
				c = frame_scoreboard::crc_byte(c, d);
				send_byte(d);
			end
			send_byte(crc_ok ? c : c ^ 8'($urandom_range(1, 255)));
		end
	endtask

	// mostly frames with random content, some noise and broken sync pairs
	task automatic random_traffic(input int budget);
		int         stop_at;
		int         pick;
		logic [7:0] ver;
		logic [7:0] who;
		logic [7:0] plen;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				ver = ($urandom_range(99) < 80) ? sb.exp_version : 8'($urandom);
				pick = $urandom_range(99);
				if (pick < 40)
					who = sb.id_table[8*$urandom_range(7) +: 8];
				else if (pick < 55)
					who = BROADCAST_ID;
				else
					who = 8'($urandom);
				// short payloads dominate, the limit and just past it get a share
				pick = $urandom_range(99);
				if (pick < 60)
					plen = 8'($urandom_range(0, 6));
				else if (pick < 80)
					plen = 8'($urandom_range(7, MAX_PAYLOAD_DEF - 1));
				else if (pick < 88)
					plen = 8'(MAX_PAYLOAD_DEF);
				else if (pick < 94)
					plen = 8'(MAX_PAYLOAD_DEF + 1);
				else
					plen = 8'($urandom_range(MAX_PAYLOAD_DEF + 2, 255));
				send_frame(ver, who, plen, $urandom_range(99) < 85);
			end else if (pick < 90) begin
				for (int i = $urandom_range(1, 4); i > 0; i--) send_byte(8'($urandom));
			end else begin
				// first sync then anything but the second one
				send_byte(SYNC_FIRST);
				send_byte(($urandom_range(1) == 1) ? SYNC_FIRST : 8'($urandom_range(0, 8'h59)));
			end
		end
	endtask

	// let every owed result come home before touching the registers
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [7:0]  pool [3];
		logic [63:0] ids;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, under the reset register values (version 1, one peer, id 1)
		// second sync wrong and itself an a5: not retaken, the 5a then falls in the hunt
		send_byte(SYNC_FIRST);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		// oversize length ends the attempt on the length byte
		send_frame(8'd1, 8'd1, 8'(MAX_PAYLOAD_DEF + 1), 1'b1);
		// empty payload, routed to entry 0
		send_frame(8'd1, 8'd1, 8'd0, 1'b1);
		// same frame with a corrupt crc byte
		send_frame(8'd1, 8'd1, 8'd0, 1'b0);

		random_traffic(200);

		// version 0, full peer table of random ids
		drain();
		write_reg(REG_EXPECTED_VERSION, 64'd0);
		write_reg(REG_PEER_COUNT, 64'(PEER_SLOTS_DEF));
		write_reg(REG_PEER_IDS, {$urandom, $urandom});
		random_traffic(220);

		// version 255, no peers at all: even broadcast finds nobody
		drain();
		write_reg(REG_EXPECTED_VERSION, 64'd255);
		write_reg(REG_PEER_COUNT, 64'd0);
		write_reg(REG_PEER_IDS, 64'd0);
		random_traffic(180);

		// count at its field maximum, table full of the broadcast id
		drain();
		write_reg(REG_EXPECTED_VERSION, 64'($urandom_range(255)));
		write_reg(REG_PEER_COUNT, 64'd15);
		write_reg(REG_PEER_IDS, {64{1'b1}});
		random_traffic(180);

		// count past the slots, table built from three ids so matches repeat
		drain();
		foreach (pool[i]) pool[i] = 8'($urandom);
		for (int i = 0; i < PEER_SLOTS_DEF; i++) ids[8*i +: 8] = pool[$urandom_range(2)];
		write_reg(REG_EXPECTED_VERSION, 64'($urandom_range(255)));
		write_reg(REG_PEER_COUNT, 64'($urandom_range(PEER_SLOTS_DEF + 1, 14)));
		write_reg(REG_PEER_IDS, ids);
		random_traffic(220);

		// a write to the undecoded index, then a partial table
		drain();
		write_reg(REG_UNUSED, {$urandom, $urandom});
		write_reg(REG_EXPECTED_VERSION, 64'd1);
		write_reg(REG_PEER_COUNT, 64'($urandom_range(1, PEER_SLOTS_DEF - 1)));
		write_reg(REG_PEER_IDS, {$urandom, $urandom});
		random_traffic(220);

		drain();
		// a spurious late result would still show up here
		repeat (DRAIN_TAIL) @(posedge clk);

		$display("covered %0d bytes and %0d checked results over six register settings",
			bytes_sent, sb.checked);
		$display("frame endings: routed %0d, bad crc %0d, bad version %0d, too long %0d, no peer %0d",
			sb.verdict_hits[V_ROUTED], sb.verdict_hits[V_BADCRC], sb.verdict_hits[V_BADVER],
			sb.verdict_hits[V_TOOLONG], sb.verdict_hits[V_NOPEER]);
		if (sb.mismatches > 10)
			$display("%0d mismatches in total", sb.mismatches);
		if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/sfcr8_pkg.sv
hw/rtl/sync_framed_crc8_frame_router_top.sv
bench/testbench.sv
